// ===== rtl/paged_translation_fifo_lru_macros.svh =====
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef PAGED_TRANSLATION_FIFO_LRU_MACROS_SVH
`define PAGED_TRANSLATION_FIFO_LRU_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptf_pkg.sv =====
`timescale 1ns / 1ps
// types, constants and helpers for the paged address translator
// used by the slot cells and the top level
package ptf_pkg;

  localparam int ADDR_BITS   = 16;
  localparam int OFFSET_BITS = 13;
  localparam int PAGE_BITS   = 3;
  localparam int PAGE_COUNT  = 8;
  localparam int FRAME_BITS  = 12;
  localparam int PHYS_BITS   = FRAME_BITS + OFFSET_BITS;
  localparam int TOTAL_BITS  = 32;
  localparam int FC_BITS     = 5;
  localparam int DATA_BITS   = 32;
  localparam int REG_ADDR_BITS = 4;

  localparam logic [1:0] REG_POLICY      = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
  localparam logic [1:0] REG_FIRST_FRAME = 2'd2;

  localparam logic [FC_BITS-1:0] FRAME_COUNT_RESET = 5'd16;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] logical_address;
    logic                 is_write;
  } ptf_request_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0]   page_number;
    logic [OFFSET_BITS-1:0] page_offset;
    logic                   page_fault;
    logic                   write_back;
    logic [PHYS_BITS-1:0]   physical_address;
    logic [TOTAL_BITS-1:0]  reads_total;
    logic [TOTAL_BITS-1:0]  writes_total;
    logic [TOTAL_BITS-1:0]  faults_total;
    logic [TOTAL_BITS-1:0]  writebacks_total;
  } ptf_result_t;

  // per-item command broadcast to every slot cell
  typedef struct packed {
    logic                  touch_en;
    logic                  evict_en;
    logic                  alloc_en;
    logic [FRAME_BITS-1:0] frame;
  } slot_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY
  } ptf_state_t;

  function automatic logic [TOTAL_BITS-1:0] sat_inc(input logic [TOTAL_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/paged_translation_fifo_lru.sv =====
`timescale 1ns / 1ps
// demand-paging address translator with fifo or lru frame replacement
// depends on ptf_pkg and ptf_slot
//
// usage:
//   item channel: an item is taken at a clock edge with start high and busy low.
//   result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot hold results off and none is needed.
//   config: apb-style port, policy at 0x0, frame_count at 0x4, first_frame
//   at 0x8; pready is tied high, write only while no item is in flight.
// timing:
//   an item passes a lookup step (page-table lookup and victim pick), then an
//   update step of the slot row (arrival and recency orders) and the page table.
//   done and the result are registered by the update step.
//   busy is high only in the lookup cycle, so a new item can be taken in the
//   update cycle, before the last item is through.
// reset:
//   synchronous; clears page valid bits, handed-out and fill counts, totals,
//   config registers to policy fifo, 16 frames, first frame 0. slot contents
//   are not cleared, only the counted part of each order is ever read.
module paged_translation_fifo_lru #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  ptf_pkg::ptf_request_t               item,
  output logic                                busy,
  output logic                                done,
  output ptf_pkg::ptf_result_t                result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptf_pkg::REG_ADDR_BITS-1:0]   paddr,
  input  logic [ptf_pkg::DATA_BITS-1:0]       pwdata,
  output logic [ptf_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);
  import ptf_pkg::*;

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int NW = (CW > FC_BITS) ? CW : FC_BITS;

  // config registers
  logic                   policy;
  logic [FC_BITS-1:0]     frame_count;
  logic [FRAME_BITS-1:0]  first_frame;

  // sequencer
  ptf_state_t state, state_next;
  logic       accept;
  logic       look_en;
  logic       apply_en;

  // captured item and lookup results
  ptf_request_t           req;
  logic                   look_fault;
  logic                   look_alloc;
  logic [FRAME_BITS-1:0]  look_frame;

  // page table
  logic [PAGE_COUNT-1:0]  pt_valid;
  logic [PAGE_COUNT-1:0]  pt_mod;
  logic [FRAME_BITS-1:0]  pt_frame [PAGE_COUNT];

  // order bookkeeping
  logic [NW-1:0]          held;
  logic [NW-1:0]          fill;
  logic [NW-1:0]          fill_next;
  logic [NW-1:0]          granted;

  // totals and result registers
  logic [TOTAL_BITS-1:0]  reads_total;
  logic [TOTAL_BITS-1:0]  writes_total;
  logic [TOTAL_BITS-1:0]  faults_total;
  logic [TOTAL_BITS-1:0]  writebacks_total;
  logic [PAGE_BITS-1:0]   out_page;
  logic [OFFSET_BITS-1:0] out_offset;
  logic                   out_fault;
  logic                   out_wb;
  logic [PHYS_BITS-1:0]   out_phys;

  // datapath
  logic [PAGE_BITS-1:0]   page;
  logic [OFFSET_BITS-1:0] offset;
  logic                   hit;
  logic                   alloc;
  logic [FRAME_BITS-1:0]  victim;
  logic [FRAME_BITS-1:0]  frame_sel;
  logic                   evict;
  logic [PAGE_COUNT-1:0]  kill;
  logic                   wb;
  slot_ctl_t              ctl;

  // slot row
  logic [FRAME_BITS-1:0]  arr_q     [MAX_FRAMES];
  logic [FRAME_BITS-1:0]  rec_q     [MAX_FRAMES];
  logic [FRAME_BITS-1:0]  arr_right [MAX_FRAMES];
  logic [FRAME_BITS-1:0]  rec_left  [MAX_FRAMES];
  logic [FRAME_BITS-1:0]  tail_chain [MAX_FRAMES+1];
  logic [MAX_FRAMES:0]    arr_found;
  logic [MAX_FRAMES:0]    rec_found;

  // ---------------- config port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_FIFO;
      frame_count <= FRAME_COUNT_RESET;
      first_frame <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_POLICY:      policy      <= pwdata[0];
        REG_FRAME_COUNT: frame_count <= pwdata[FC_BITS-1:0];
        REG_FIRST_FRAME: first_frame <= pwdata[FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POLICY:      prdata = {{(DATA_BITS-1){1'b0}}, policy};
      REG_FRAME_COUNT: prdata = {{(DATA_BITS-FC_BITS){1'b0}}, frame_count};
      REG_FIRST_FRAME: prdata = {{(DATA_BITS-FRAME_BITS){1'b0}}, first_frame};
      default:         prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign accept = start && !busy;

  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_LOOK : S_IDLE;
      S_LOOK:  state_next = S_APPLY;
      S_APPLY: state_next = accept ? S_LOOK : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    look_en  = 1'b0;
    apply_en = 1'b0;
    case (state)
      S_LOOK: begin
        busy    = 1'b1;
        look_en = 1'b1;
      end
      S_APPLY: apply_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= item;
    end
  end

  // ---------------- lookup step ----------------
  assign page   = req.logical_address[ADDR_BITS-1 -: PAGE_BITS];
  assign offset = req.logical_address[OFFSET_BITS-1:0];

  always_comb begin
    if (frame_count == '0) begin
      granted = NW'(1);
    end else if (NW'(frame_count) > NW'(MAX_FRAMES)) begin
      granted = NW'(MAX_FRAMES);
    end else begin
      granted = NW'(frame_count);
    end
  end

  assign hit    = pt_valid[page];
  assign alloc  = !hit && (held < granted);
  assign victim = (policy == POLICY_LRU) ? tail_chain[MAX_FRAMES] : arr_q[0];

  always_comb begin
    if (hit) begin
      frame_sel = pt_frame[page];
    end else if (alloc) begin
      frame_sel = first_frame + FRAME_BITS'(held);
    end else begin
      frame_sel = victim;
    end
  end

  always_ff @(posedge clk) begin
    if (look_en) begin
      look_fault <= !hit;
      look_alloc <= alloc;
      look_frame <= frame_sel;
    end
  end

  // ---------------- update step ----------------
  assign evict = look_fault && !look_alloc;

  always_comb begin
    for (int i = 0; i < PAGE_COUNT; i++) begin
      kill[i] = evict && pt_valid[i] && (pt_frame[i] == look_frame);
    end
  end

  assign wb = |(kill & pt_mod);

  assign ctl.touch_en = apply_en;
  assign ctl.evict_en = apply_en && evict;
  assign ctl.alloc_en = apply_en && look_alloc;
  assign ctl.frame    = look_frame;

  always_comb begin
    fill_next = fill;
    if (!rec_found[MAX_FRAMES] && (fill < NW'(MAX_FRAMES))) begin
      fill_next = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= '0;
    end else if (apply_en) begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
        if (PAGE_BITS'(i) == page) begin
          pt_valid[i] <= 1'b1;
        end else if (kill[i]) begin
          pt_valid[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_en) begin
      if (look_fault) begin
        pt_mod[page]   <= req.is_write;
        pt_frame[page] <= look_frame;
      end else begin
        pt_mod[page]   <= pt_mod[page] | req.is_write;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held             <= '0;
      fill             <= '0;
      reads_total      <= '0;
      writes_total     <= '0;
      faults_total     <= '0;
      writebacks_total <= '0;
      done             <= 1'b0;
    end else begin
      done <= apply_en;
      if (apply_en) begin
        fill <= fill_next;
        if (look_alloc) begin
          held <= held + 1'b1;
        end
        if (req.is_write) begin
          writes_total <= sat_inc(writes_total);
        end else begin
          reads_total <= sat_inc(reads_total);
        end
        if (look_fault) begin
          faults_total <= sat_inc(faults_total);
        end
        if (wb) begin
          writebacks_total <= sat_inc(writebacks_total);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_en) begin
      out_page   <= page;
      out_offset <= offset;
      out_fault  <= look_fault;
      out_wb     <= wb;
      out_phys   <= {look_frame, offset};
    end
  end

  always_comb begin
    result.page_number      = out_page;
    result.page_offset      = out_offset;
    result.page_fault       = out_fault;
    result.write_back       = out_wb;
    result.physical_address = out_phys;
    result.reads_total      = reads_total;
    result.writes_total     = writes_total;
    result.faults_total     = faults_total;
    result.writebacks_total = writebacks_total;
  end

  // ---------------- slot row ----------------
  assign arr_found[0]  = 1'b0;
  assign rec_found[0]  = 1'b0;
  assign tail_chain[0] = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_slot
    if (g == MAX_FRAMES - 1) begin : g_last
      assign arr_right[g] = arr_q[g];
    end else begin : g_inner
      assign arr_right[g] = arr_q[g+1];
    end
    if (g == 0) begin : g_first
      assign rec_left[g] = ctl.frame;
    end else begin : g_rest
      assign rec_left[g] = rec_q[g-1];
    end

    ptf_slot #(
      .INDEX (g),
      .NW    (NW)
    ) u_slot (
      .clk           (clk),
      .ctl           (ctl),
      .held          (held),
      .fill          (fill),
      .arr_right     (arr_right[g]),
      .rec_left      (rec_left[g]),
      .arr_found_in  (arr_found[g]),
      .rec_found_in  (rec_found[g]),
      .rec_any       (rec_found[MAX_FRAMES]),
      .tail_in       (tail_chain[g]),
      .arr_q         (arr_q[g]),
      .rec_q         (rec_q[g]),
      .arr_found_out (arr_found[g+1]),
      .rec_found_out (rec_found[g+1]),
      .tail_out      (tail_chain[g+1])
    );
  end

endmodule

// ===== rtl/ptf_slot.sv =====
`timescale 1ns / 1ps
// one slot of the frame order chains: arrival order and recency order
// depends on ptf_pkg; neighbors pass data and first-match flags along the row
module ptf_slot #(
  parameter int INDEX = 0,
  parameter int NW    = 5
) (
  input  logic                            clk,
  input  ptf_pkg::slot_ctl_t              ctl,
  input  logic [NW-1:0]                   held,
  input  logic [NW-1:0]                   fill,
  input  logic [ptf_pkg::FRAME_BITS-1:0]  arr_right,
  input  logic [ptf_pkg::FRAME_BITS-1:0]  rec_left,
  input  logic                            arr_found_in,
  input  logic                            rec_found_in,
  input  logic                            rec_any,
  input  logic [ptf_pkg::FRAME_BITS-1:0]  tail_in,
  output logic [ptf_pkg::FRAME_BITS-1:0]  arr_q,
  output logic [ptf_pkg::FRAME_BITS-1:0]  rec_q,
  output logic                            arr_found_out,
  output logic                            rec_found_out,
  output logic [ptf_pkg::FRAME_BITS-1:0]  tail_out
);
  import ptf_pkg::*;

  logic arr_valid;
  logic arr_sel;
  logic arr_last;
  logic rec_valid;
  logic rec_match;
  logic rec_load;

  assign arr_valid = NW'(INDEX) < held;
  assign arr_sel   = arr_found_in || (arr_valid && (arr_q == ctl.frame));
  assign arr_last  = held == NW'(INDEX + 1);
  assign arr_found_out = arr_sel;

  assign rec_valid = NW'(INDEX) < fill;
  assign rec_match = rec_valid && (rec_q == ctl.frame);
  assign rec_found_out = rec_found_in || rec_match;

  // slots up to the hit (or up to the insert point) move one step toward the old end
  assign rec_load = ctl.touch_en && (rec_any ? !rec_found_in : (NW'(INDEX) <= fill));

  assign tail_out = tail_in | ((fill == NW'(INDEX + 1)) ? rec_q : '0);

  always_ff @(posedge clk) begin
    if (ctl.evict_en && arr_valid && arr_sel) begin
      // close the gap left by the victim and put it back at the newest end
      arr_q <= arr_last ? ctl.frame : arr_right;
    end else if (ctl.alloc_en && (held == NW'(INDEX))) begin
      arr_q <= ctl.frame;
    end
    if (rec_load) begin
      rec_q <= rec_left;
    end
  end

endmodule

// ===== rtl/ptf_checker.sv =====
`timescale 1ns / 1ps
// port-level timing checks for the paged address translator, bound to the top
// depends on paged_translation_fifo_lru_macros.svh
`include "paged_translation_fifo_lru_macros.svh"

module ptf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `PTF_ASSERT_NEXT(a_busy_after_accept, clk, rst, start && !busy, busy, "busy missing after item")
  `PTF_ASSERT_NEXT(a_busy_single, clk, rst, busy, !busy, "busy held for more than one cycle")
  `PTF_ASSERT_NOW(a_done_latency, clk, rst, start && !busy, ##3 done, "no result three cycles after item")
  `PTF_ASSERT_NOW(a_done_has_item, clk, rst, done, $past(start && !busy, 3), "result without an item")

endmodule

bind paged_translation_fifo_lru ptf_checker u_ptf_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
